// ===== rtl/core/flc_pkg.sv =====
// ----------------------------------------------------------------------------
// flc_pkg
// Shared types and constants of the full linear convolution core: op codes,
// register map, sequencer states and the control/status bundles of the MAC.
// ----------------------------------------------------------------------------
package flc_pkg;

  // default kernel memory depth
  localparam int MAX_TAPS_DEF = 256;

  // sample and tap word width, unsigned Q0.32
  localparam int DATA_W = 32;

  // kernel length register
  localparam int       KLEN_W     = 9;
  localparam logic [KLEN_W-1:0] KLEN_RESET = 9'd1;

  // configuration port
  localparam int   CFG_AW   = 3;
  localparam int   CFG_DW   = 32;
  localparam logic REG_KLEN = 1'b0;   // word index of kernel_len

  // op codes carried in tuser of the input beat
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_FLUSH  = 2'd2;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_DRAIN,
    S_OUT
  } flc_state_t;

  // control into the MAC datapath
  typedef struct packed {
    logic clear;    // start of a new output sum
    logic rd_vld;   // memory read data is valid this cycle
    logic mask;     // history word is live (not yet cleared)
  } mac_ctl_t;

  // status back from the MAC datapath
  typedef struct packed {
    logic busy;     // a product is still being added
    logic sat;      // sum is 1.0 or more
  } mac_sts_t;

endpackage

// ===== rtl/core/full_linear_convolution_core.sv =====
// Sequencing: a sample or flush beat walks S_MAC, S_DRAIN and S_OUT; its result
//   beat is registered in S_OUT. A load beat, an ignored flush or an unused op stays idle.
// A new beat is taken only in S_IDLE, once the single MAC has walked the tap and
//   history memories one tap per cycle and the result has been registered.
// Reset: synchronous, active low; delay line empty, pointer and tail count zero,
//   kernel_len 1. Tap memory holds whatever was last loaded.
// ----------------------------------------------------------------------------
// full_linear_convolution_core
// Streaming FIR for full linear convolution: kernel taps and sample history in
// two synchronous memories, one multiply-accumulate per tap, tail flush marking.
// ----------------------------------------------------------------------------
module full_linear_convolution_core
  import flc_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // input stream
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [39:0]       in_tdata,    // [7:0] tap_index, [39:8] value
  input  logic [1:0]        in_tuser,    // [1:0] op
  // result stream
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,   // [31:0] result_value
  output logic              out_tuser,   // [0] saturated
  output logic              out_tlast,   // is_last
  // configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  localparam int AW      = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int FW      = $clog2(MAX_TAPS + 1);
  localparam int LEN_W   = (FW > KLEN_W) ? FW : KLEN_W;

  flc_state_t          state_r, state_nxt;
  logic [KLEN_W-1:0]   kernel_len_r;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [FW-1:0]       fill_r, fill_nxt;
  logic [KLEN_W-1:0]   flush_r, flush_nxt;
  logic [AW-1:0]       k_r, k_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  logic                last_r, last_nxt;

  logic [DATA_W-1:0]   tap_mem [MAX_TAPS];
  logic [DATA_W-1:0]   hist_mem [MAX_TAPS];
  logic [DATA_W-1:0]   tap_rd_r;
  logic [DATA_W-1:0]   hist_rd_r;
  logic                rd_vld_r;
  logic                mask_r;

  logic                out_tvalid_r;
  logic [DATA_W-1:0]   out_data_r;
  logic                out_sat_r;
  logic                out_last_r;

  logic [7:0]          in_tap_index;
  logic [DATA_W-1:0]   in_value;
  logic                in_acc;
  logic                is_load, is_sample, is_flush;
  logic [LEN_W-1:0]    klen_ext, len_eff, len_m1, flush_ext;
  logic                flush_ok;
  logic                push;
  logic                tap_we;
  logic [AW-1:0]       tap_waddr;
  logic [AW-1:0]       ptr_inc;
  logic                issue;
  logic                last_issue;
  logic                out_load;
  logic                cfg_wr;
  logic                cfg_hit;

  mac_ctl_t            mac_ctl;
  mac_sts_t            mac_sts;
  logic [DATA_W-1:0]   mac_result;

  // beat fields
  assign in_tap_index = in_tdata[7:0];
  assign in_value     = in_tdata[39:8];
  assign in_acc       = in_tvalid & in_tready;
  assign is_load      = (in_tuser == OP_LOAD);
  assign is_sample    = (in_tuser == OP_SAMPLE);
  assign is_flush     = (in_tuser == OP_FLUSH);

  // effective kernel length, clamped to 1..MAX_TAPS
  always_comb begin
    klen_ext = LEN_W'(kernel_len_r);
    if (klen_ext == '0) begin
      len_eff = LEN_W'(1);
    end else if (klen_ext > LEN_W'(MAX_TAPS)) begin
      len_eff = LEN_W'(MAX_TAPS);
    end else begin
      len_eff = klen_ext;
    end
  end
  assign len_m1    = len_eff - LEN_W'(1);
  assign flush_ext = LEN_W'(flush_r);
  assign flush_ok  = (flush_ext < len_m1);

  // decode of the accepted beat
  assign push      = in_acc & (is_sample | (is_flush & flush_ok));
  assign tap_we    = in_acc & is_load & (32'(in_tap_index) < 32'(MAX_TAPS));
  assign tap_waddr = AW'(in_tap_index);
  assign ptr_inc   = (ptr_r == AW'(MAX_TAPS - 1)) ? '0 : ptr_r + AW'(1);
  assign last_issue = (LEN_W'(k_r) == len_m1);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (push) state_nxt = S_MAC;
      S_MAC:   if (last_issue) state_nxt = S_DRAIN;
      S_DRAIN: if (!rd_vld_r && !mac_sts.busy) state_nxt = S_OUT;
      S_OUT:   if (!out_tvalid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_tready = 1'b0;
    issue     = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_MAC:   issue     = 1'b1;
      S_DRAIN: ;
      S_OUT:   out_load  = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  // pointer, fill count, tail count and tap walk
  always_comb begin
    ptr_nxt   = ptr_r;
    fill_nxt  = fill_r;
    flush_nxt = flush_r;
    k_nxt     = k_r;
    slot_nxt  = slot_r;
    last_nxt  = last_r;
    if (in_acc && is_load) begin
      ptr_nxt   = '0;
      fill_nxt  = '0;
      flush_nxt = '0;
    end else if (push) begin
      ptr_nxt   = ptr_inc;
      fill_nxt  = (fill_r == FW'(MAX_TAPS)) ? fill_r : fill_r + FW'(1);
      flush_nxt = is_sample ? '0 : flush_r + KLEN_W'(1);
      last_nxt  = is_flush && ((flush_ext + LEN_W'(1)) == len_m1);
      k_nxt     = '0;
      slot_nxt  = ptr_inc;
    end else if (issue) begin
      k_nxt    = k_r + AW'(1);
      slot_nxt = (slot_r == '0) ? AW'(MAX_TAPS - 1) : slot_r - AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ptr_r    <= '0;
      fill_r   <= '0;
      flush_r  <= '0;
      k_r      <= '0;
      slot_r   <= '0;
      last_r   <= 1'b0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ptr_r    <= ptr_nxt;
      fill_r   <= fill_nxt;
      flush_r  <= flush_nxt;
      k_r      <= k_nxt;
      slot_r   <= slot_nxt;
      last_r   <= last_nxt;
      rd_vld_r <= issue;
    end
  end

  // kernel tap memory
  always_ff @(posedge clk) begin
    if (tap_we) begin
      tap_mem[tap_waddr] <= in_value;
    end
    if (issue) begin
      tap_rd_r <= tap_mem[k_r];
    end
  end

  // sample history memory, flush pushes a zero
  always_ff @(posedge clk) begin
    if (push) begin
      hist_mem[ptr_inc] <= is_sample ? in_value : '0;
    end
    if (issue) begin
      hist_rd_r <= hist_mem[slot_r];
      mask_r    <= (LEN_W'(k_r) < LEN_W'(fill_r));
    end
  end

  // multiply-accumulate
  assign mac_ctl.clear  = push;
  assign mac_ctl.rd_vld = rd_vld_r;
  assign mac_ctl.mask   = mask_r;

  flc_mac #(
    .MAX_TAPS (MAX_TAPS)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (mac_ctl),
    .tap_data  (tap_rd_r),
    .hist_data (hist_rd_r),
    .sts       (mac_sts),
    .result    (mac_result)
  );

  // result output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= mac_result;
      out_sat_r  <= mac_sts.sat;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[CFG_AW-1] == REG_KLEN);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready & cfg_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_len_r <= KLEN_RESET;
    end else if (cfg_wr) begin
      kernel_len_r <= cfg_pwdata[KLEN_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_psel && cfg_hit) ? CFG_DW'(kernel_len_r) : '0;

  // a load beat never starts the tap walk
  a_load_no_walk: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_load) |=> (state_r == S_IDLE))
    else $error("load beat started a tap walk");

  // fill count stays within the history depth
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r <= FW'(MAX_TAPS)))
    else $error("history fill count beyond depth");

  // the result is taken only once the MAC pipeline has emptied
  a_out_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!rd_vld_r && !mac_sts.busy))
    else $error("result loaded while MAC pipeline busy");

  // a new result beat only appears from the output state
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == S_OUT))
    else $error("result beat raised outside output state");

  // the tap walk never runs past the kernel length
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (LEN_W'(k_r) <= len_m1))
    else $error("tap walk beyond kernel length");

endmodule

// ===== rtl/core/flc_mac.sv =====
// ----------------------------------------------------------------------------
// flc_mac
// Single multiply-accumulate unit: registered 32x32 product, exact wide
// accumulator, truncation to Q0.32 with saturation at the top.
// ----------------------------------------------------------------------------
module flc_mac
  import flc_pkg::*;
#(
  parameter int MAX_TAPS = MAX_TAPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mac_ctl_t          ctl,
  input  logic [DATA_W-1:0] tap_data,
  input  logic [DATA_W-1:0] hist_data,
  output mac_sts_t          sts,
  output logic [DATA_W-1:0] result
);

  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;

  logic              mul_vld_r;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_nxt;
  logic [ACC_W-1:0]  acc_r;
  logic [ACC_W-1:0]  acc_nxt;

  // product of the current tap and history word, zero for a cleared slot
  assign prod_nxt = ctl.mask ? ({{DATA_W{1'b0}}, tap_data} * {{DATA_W{1'b0}}, hist_data})
                             : '0;

  // accumulate the exact Q0.64 products
  always_comb begin
    acc_nxt = acc_r;
    if (ctl.clear) begin
      acc_nxt = '0;
    end else if (mul_vld_r) begin
      acc_nxt = acc_r + ACC_W'(prod_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_vld_r <= 1'b0;
    end else begin
      mul_vld_r <= ctl.rd_vld;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
  end

  // truncate to Q0.32, saturate when any integer bit is set
  assign sts.sat  = |acc_r[ACC_W-1:PROD_W];
  assign sts.busy = mul_vld_r;
  assign result   = sts.sat ? {DATA_W{1'b1}} : acc_r[PROD_W-1:DATA_W];

endmodule
